FILE: rtl/core/rgt_pkg.sv
// Shared types and constants of the resource grant table unit.
// No dependencies; every other file of the block depends on this package.
package rgt_pkg;

  localparam int TYPES = 3;
  localparam int DEF_PROCESSES = 16;
  localparam int DEF_COUNT_BITS = 8;
  localparam int FUNC_BITS = 2;
  localparam int PROC_BITS = 4;
  localparam int STATUS_BITS = 2;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [FUNC_BITS-1:0] FUNC_GET = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_FREE = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_ADMIT = 2'd2;

  localparam logic [STATUS_BITS-1:0] STATUS_DONE = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_BLOCKED = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_OVER_MAX = 2'd2;
  localparam logic [STATUS_BITS-1:0] STATUS_OVER_HELD = 2'd3;

  typedef struct packed {
    logic capture;
    logic commit;
  } rgt_cmd_t;

endpackage

FILE: rtl/core/rgt_req_if.sv
// Request channel of the resource grant table unit: valid, ready and one item.
// Depends on rgt_pkg for field widths.
interface rgt_req_if #(
  parameter int COUNT_BITS = rgt_pkg::DEF_COUNT_BITS
);
  logic valid;
  logic ready;
  logic [rgt_pkg::FUNC_BITS-1:0] func;
  logic [rgt_pkg::PROC_BITS-1:0] proc;
  logic [COUNT_BITS-1:0] amount0;
  logic [COUNT_BITS-1:0] amount1;
  logic [COUNT_BITS-1:0] amount2;

  modport source (output valid, func, proc, amount0, amount1, amount2, input ready);
  modport sink (input valid, func, proc, amount0, amount1, amount2, output ready);
endinterface

FILE: rtl/core/rgt_rsp_if.sv
// Result channel of the resource grant table unit: valid, ready and one item.
// Depends on rgt_pkg for field widths.
interface rgt_rsp_if #(
  parameter int COUNT_BITS = rgt_pkg::DEF_COUNT_BITS
);
  logic valid;
  logic ready;
  logic [rgt_pkg::STATUS_BITS-1:0] status;
  logic wake_scheduler;
  logic [COUNT_BITS-1:0] avail0;
  logic [COUNT_BITS-1:0] avail1;
  logic [COUNT_BITS-1:0] avail2;

  modport source (output valid, status, wake_scheduler, avail0, avail1, avail2, input ready);
  modport sink (input valid, status, wake_scheduler, avail0, avail1, avail2, output ready);
endinterface

FILE: rtl/core/rgt_ctrl.sv
// Controller of the resource grant table unit: handshakes and sequencing.
// Depends on rgt_pkg for the command struct.
module rgt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output rgt_pkg::rgt_cmd_t cmd
);
  import rgt_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic rsp_valid_next;

  assign req_ready = (state == S_IDLE);
  assign cmd.capture = req_valid && req_ready;
  assign cmd.commit = (state == S_EXEC) && (!rsp_valid || rsp_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.capture) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.commit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (cmd.commit) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

FILE: rtl/core/rgt_dpath.sv
// Datapath of the resource grant table unit: process tables, pool counts and
// the result register. Depends on rgt_pkg for codes and the command struct.
module rgt_dpath #(
  parameter int PROCESSES = rgt_pkg::DEF_PROCESSES,
  parameter int COUNT_BITS = rgt_pkg::DEF_COUNT_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  rgt_pkg::rgt_cmd_t                  cmd,
  input  logic [rgt_pkg::FUNC_BITS-1:0]      func,
  input  logic [rgt_pkg::PROC_BITS-1:0]      proc,
  input  logic [COUNT_BITS-1:0]              amount0,
  input  logic [COUNT_BITS-1:0]              amount1,
  input  logic [COUNT_BITS-1:0]              amount2,
  input  logic                               cfg_we,
  input  logic [rgt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [COUNT_BITS-1:0]              cfg_data,
  output logic [rgt_pkg::STATUS_BITS-1:0]    status,
  output logic                               wake_scheduler,
  output logic [COUNT_BITS-1:0]              avail0,
  output logic [COUNT_BITS-1:0]              avail1,
  output logic [COUNT_BITS-1:0]              avail2
);
  import rgt_pkg::*;

  localparam int ADDR_BITS = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef logic [TYPES-1:0][COUNT_BITS-1:0] triple_t;

  triple_t max_mem [PROCESSES];
  triple_t held_mem [PROCESSES];

  triple_t max_rd;
  triple_t held_rd;
  triple_t amt_q;
  triple_t avail;
  triple_t avail_next;
  triple_t max_wdata;
  triple_t held_wdata;
  logic [FUNC_BITS-1:0] func_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic proc_ok_q;
  logic max_we;
  logic held_we;
  logic over_max;
  logic short;
  logic over_held;
  logic [STATUS_BITS-1:0] status_next;
  logic wake_next;
  logic [COUNT_BITS:0] sum_held_amt;
  logic [COUNT_BITS:0] sum_release;
  logic [COUNT_BITS:0] sum_free;
  triple_t released;
  triple_t freed;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      max_rd <= max_mem[ADDR_BITS'(proc)];
      held_rd <= held_mem[ADDR_BITS'(proc)];
      func_q <= func;
      addr_q <= ADDR_BITS'(proc);
      proc_ok_q <= (32'(proc) < 32'(PROCESSES));
      amt_q <= {amount2, amount1, amount0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && max_we) begin
      max_mem[addr_q] <= max_wdata;
    end
    if (cmd.commit && held_we) begin
      held_mem[addr_q] <= held_wdata;
    end
  end

  always_comb begin
    over_max = 1'b0;
    short = 1'b0;
    over_held = 1'b0;
    sum_held_amt = '0;
    sum_release = '0;
    sum_free = '0;
    released = '0;
    freed = '0;
    for (int t = 0; t < TYPES; t++) begin
      sum_held_amt = {1'b0, held_rd[t]} + {1'b0, amt_q[t]};
      if (sum_held_amt > {1'b0, max_rd[t]}) begin
        over_max = 1'b1;
      end
      if (amt_q[t] > avail[t]) begin
        short = 1'b1;
      end
      if (amt_q[t] > held_rd[t]) begin
        over_held = 1'b1;
      end
      sum_release = {1'b0, avail[t]} + {1'b0, held_rd[t]};
      released[t] = sum_release[COUNT_BITS] ? COUNT_MAX : sum_release[COUNT_BITS-1:0];
      sum_free = {1'b0, avail[t]} + {1'b0, amt_q[t]};
      freed[t] = sum_free[COUNT_BITS] ? COUNT_MAX : sum_free[COUNT_BITS-1:0];
    end
  end

  always_comb begin
    status_next = STATUS_DONE;
    wake_next = 1'b0;
    avail_next = avail;
    max_we = 1'b0;
    held_we = 1'b0;
    max_wdata = amt_q;
    held_wdata = '0;
    if (proc_ok_q) begin
      unique case (func_q)
        FUNC_ADMIT: begin
          max_we = 1'b1;
          held_we = 1'b1;
        end
        FUNC_GET: begin
          priority if (over_max) begin
            status_next = STATUS_OVER_MAX;
            avail_next = released;
            held_we = 1'b1;
          end else if (short) begin
            status_next = STATUS_BLOCKED;
          end else begin
            held_we = 1'b1;
            for (int t = 0; t < TYPES; t++) begin
              held_wdata[t] = held_rd[t] + amt_q[t];
              avail_next[t] = avail[t] - amt_q[t];
            end
          end
        end
        FUNC_FREE: begin
          priority if (over_held) begin
            status_next = STATUS_OVER_HELD;
            avail_next = released;
            held_we = 1'b1;
          end else begin
            held_we = 1'b1;
            wake_next = 1'b1;
            avail_next = freed;
            for (int t = 0; t < TYPES; t++) begin
              held_wdata[t] = held_rd[t] - amt_q[t];
            end
          end
        end
        default: begin
          status_next = STATUS_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avail <= '0;
    end else if (cfg_we && (cfg_index < CFG_INDEX_BITS'(TYPES))) begin
      avail[cfg_index] <= cfg_data;
    end else if (cmd.commit) begin
      avail <= avail_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status <= status_next;
      wake_scheduler <= wake_next;
      avail0 <= avail_next[0];
      avail1 <= avail_next[1];
      avail2 <= avail_next[2];
    end
  end

endmodule

FILE: rtl/core/resource_grant_table_unit.sv
// Resource grant table unit: a process table that grants and takes back
// three resource types. The request channel carries func, proc and three
// amounts; the result channel carries status, wake_scheduler and the three
// available counts after the item. Configuration writes load the pool size
// of a type into its available count; the user must make them only while
// the unit idles, as the unit itself does not enforce this. Each item first
// reads the maximum and holding tables at the process index, then is decided
// and written back; a new item is not accepted until the last is decided.
// The result is registered in the output register when the item is decided;
// the next item is accepted while that result still waits. If the receiver
// stalls, one more item is accepted and its decision is held until the
// output register frees; no further item is taken meanwhile.
// Reset clears the available counts to zero and empties the output register.
// The tables hold no valid state after reset: a process must be admitted
// before it is used.
// Depends on rgt_pkg, rgt_req_if, rgt_rsp_if, rgt_ctrl and rgt_dpath.
module resource_grant_table_unit #(
  parameter int PROCESSES = rgt_pkg::DEF_PROCESSES,
  parameter int COUNT_BITS = rgt_pkg::DEF_COUNT_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  rgt_req_if.sink                            req,
  rgt_rsp_if.source                          rsp,
  input  logic                               cfg_we,
  input  logic [rgt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [COUNT_BITS-1:0]              cfg_data
);
  import rgt_pkg::*;

  rgt_cmd_t cmd;

  rgt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  rgt_dpath #(
    .PROCESSES  (PROCESSES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .func           (req.func),
    .proc           (req.proc),
    .amount0        (req.amount0),
    .amount1        (req.amount1),
    .amount2        (req.amount2),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .status         (rsp.status),
    .wake_scheduler (rsp.wake_scheduler),
    .avail0         (rsp.avail0),
    .avail1         (rsp.avail1),
    .avail2         (rsp.avail2)
  );

`ifndef ASSERT_OFF
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("item accepted while the previous one is still in work");

  a_wake_on_done: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.wake_scheduler) |-> (rsp.status == STATUS_DONE))
    else $error("wake raised with a failing status");

  a_result_after_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(!req.ready))
    else $error("result produced outside the execute step");
`endif

endmodule
